@@ design/fwm_pkg.sv @@
package fwm_pkg;

    // Field widths fixed by the item format.
    localparam int TS_W  = 64;
    localparam int DUR_W = 32;
    localparam int FPS_W = 6;
    localparam int SUM_W = DUR_W + 1;

    // Default window depth and one-second threshold after reset.
    localparam int               WINDOW_FRAMES_DEF = 61;
    localparam logic [DUR_W-1:0] ONE_SECOND_RESET  = 32'd46882320;

    // Operation codes of an input item.
    localparam logic OP_FRAME   = 1'b0;
    localparam logic OP_SET_REF = 1'b1;

    // Write request into the duration ring.
    typedef struct packed {
        logic             en;
        logic [DUR_W-1:0] data;
    } t_ring_wr;

endpackage

@@ design/fwm_in_if.sv @@
interface fwm_in_if;
    import fwm_pkg::*;

    logic            valid;
    logic            ready;
    logic            operation;
    logic [TS_W-1:0] timestamp;

    modport source (output valid, output operation, output timestamp, input ready);
    modport sink   (input valid, input operation, input timestamp, output ready);

endinterface

@@ design/fwm_out_if.sv @@
interface fwm_out_if;
    import fwm_pkg::*;

    logic             valid;
    logic             ready;
    logic [FPS_W-1:0] fps_estimate;

    modport source (output valid, output fps_estimate, input ready);
    modport sink   (input valid, input fps_estimate, output ready);

endinterface

@@ design/fwm_ring.sv @@
module fwm_ring #(
    parameter int WINDOW_FRAMES = fwm_pkg::WINDOW_FRAMES_DEF,
    parameter int SLOT_W        = $clog2(WINDOW_FRAMES)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fwm_pkg::t_ring_wr         i_wr,
    input  logic [SLOT_W-1:0]         i_wr_addr,
    input  logic [SLOT_W-1:0]         i_rd_addr,
    output logic [fwm_pkg::DUR_W-1:0] o_rd_data
);
    import fwm_pkg::*;

    logic [DUR_W-1:0]         r_mem [WINDOW_FRAMES];
    logic [WINDOW_FRAMES-1:0] r_vld;
    logic [DUR_W-1:0]         r_rd_data;
    logic                     r_rd_vld;

    // Duration storage, one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Written flags; an entry never written reads as a zero-length frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

@@ design/fwm_seq.sv @@
module fwm_seq #(
    parameter int WINDOW_FRAMES = fwm_pkg::WINDOW_FRAMES_DEF,
    parameter int SLOT_W        = $clog2(WINDOW_FRAMES)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [fwm_pkg::DUR_W-1:0] i_threshold,
    fwm_in_if.sink                    i_in,
    fwm_out_if.source                 o_out,
    output fwm_pkg::t_ring_wr         o_wr,
    output logic [SLOT_W-1:0]         o_wr_addr,
    output logic [SLOT_W-1:0]         o_rd_addr,
    input  logic [fwm_pkg::DUR_W-1:0] i_rd_data
);
    import fwm_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_FRAMES + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [TS_W-1:0]  r_ref, n_ref;
    logic [SLOT_W-1:0] r_wslot, n_wslot;
    logic [SLOT_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic             r_pend, n_pend;
    logic [CNT_W-1:0] r_est, n_est;
    logic             r_out_vld, n_out_vld;
    logic [FPS_W-1:0] r_out_fps, n_out_fps;

    logic             accept;
    logic [TS_W-1:0]  elapsed;
    logic [SUM_W-1:0] sum_add;
    logic [CNT_W-1:0] cnt_inc;

    assign accept  = i_in.valid && i_in.ready;
    assign elapsed = i_in.timestamp - r_ref;
    assign sum_add = r_sum + {1'b0, i_rd_data};
    assign cnt_inc = r_cnt + CNT_W'(1);

    // Ring access: a frame item writes at the current slot, the walk reads backwards.
    assign o_wr.en   = accept && (i_in.operation == OP_FRAME);
    assign o_wr.data = elapsed[DUR_W-1:0];
    assign o_wr_addr = r_wslot;
    assign o_rd_addr = r_pos;

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_vld;
    assign o_out.fps_estimate = r_out_fps;

    // Next-state logic of the walk sequencer.
    always_comb begin
        n_state   = r_state;
        n_ref     = r_ref;
        n_wslot   = r_wslot;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_pend    = r_pend;
        n_est     = r_est;
        n_out_vld = r_out_vld;
        n_out_fps = r_out_fps;

        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ref = i_in.timestamp;
                    if (i_in.operation == OP_FRAME) begin
                        n_wslot = (r_wslot == SLOT_W'(WINDOW_FRAMES - 1)) ?
                                  '0 : r_wslot + SLOT_W'(1);
                        n_pos   = r_wslot;
                        n_cnt   = '0;
                        n_sum   = '0;
                        n_pend  = 1'b0;
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // Issue the next read each cycle; consume the one issued last cycle.
                n_pos  = (r_pos == '0) ? SLOT_W'(WINDOW_FRAMES - 1) : r_pos - SLOT_W'(1);
                n_pend = 1'b1;
                if (r_pend) begin
                    n_sum = sum_add;
                    n_cnt = cnt_inc;
                    if (sum_add > {1'b0, i_threshold}) begin
                        n_est   = cnt_inc;
                        n_state = S_FLUSH;
                    end else if (cnt_inc == CNT_W'(WINDOW_FRAMES)) begin
                        n_est   = CNT_W'(WINDOW_FRAMES - 1);
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                // Hand the result to the output register once it is free.
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld = 1'b1;
                    n_out_fps = FPS_W'(r_est);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ref     <= '0;
            r_wslot   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ref     <= n_ref;
            r_wslot   <= n_wslot;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    // Walk datapath registers.
    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_cnt     <= n_cnt;
        r_sum     <= n_sum;
        r_est     <= n_est;
        r_out_fps <= n_out_fps;
    end

endmodule

@@ design/frame_rate_window_meter_top.sv @@
// Frame item: occupies the block while the walk sums n ring entries (n from 1 to
// WINDOW_FRAMES); the walk reads one duration per cycle from the ring memory, and
// the result goes to the output register once the walk ends and that register is free.
// A set-reference item only loads the reference time and gives no result.
// Reset (synchronous, active low) clears the ring's written flags, the write slot
// and the reference time, and loads the one-second threshold with its default.
module frame_rate_window_meter_top #(
    parameter int WINDOW_FRAMES = fwm_pkg::WINDOW_FRAMES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [fwm_pkg::DUR_W-1:0] i_cfg_wdata,
    fwm_in_if.sink                    i_in,
    fwm_out_if.source                 o_out
);
    import fwm_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW_FRAMES);

    logic [DUR_W-1:0]  r_one_second;
    t_ring_wr          ring_wr;
    logic [SLOT_W-1:0] ring_wr_addr;
    logic [SLOT_W-1:0] ring_rd_addr;
    logic [DUR_W-1:0]  ring_rd_data;

    // One-second threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_second <= ONE_SECOND_RESET;
        end else if (i_cfg_we) begin
            r_one_second <= i_cfg_wdata;
        end
    end

    fwm_seq #(
        .WINDOW_FRAMES (WINDOW_FRAMES),
        .SLOT_W        (SLOT_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_one_second),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_wr        (ring_wr),
        .o_wr_addr   (ring_wr_addr),
        .o_rd_addr   (ring_rd_addr),
        .i_rd_data   (ring_rd_data)
    );

    fwm_ring #(
        .WINDOW_FRAMES (WINDOW_FRAMES),
        .SLOT_W        (SLOT_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (ring_wr),
        .i_wr_addr (ring_wr_addr),
        .i_rd_addr (ring_rd_addr),
        .o_rd_data (ring_rd_data)
    );

endmodule

@@ design/fwm_checker.sv @@
module fwm_checker #(
    parameter int WINDOW_FRAMES = fwm_pkg::WINDOW_FRAMES_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_in_operation,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [fwm_pkg::FPS_W-1:0] i_out_fps
);
    import fwm_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_fps)))
        else $error("result item dropped or changed while stalled");

    // A frame item is walked before the next item is taken.
    a_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_operation == OP_FRAME) |=> !i_in_ready)
        else $error("input taken during a window walk");

    // A set-reference item never produces a result.
    a_setref_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_operation == OP_SET_REF && !i_out_valid) |=> !i_out_valid)
        else $error("result produced by a set-reference item");

    // A new result only follows a walk, during which input is held off.
    a_result_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a walk");

    // The estimate is at least one frame when the window fits the field.
    a_fps_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_fps != '0 || WINDOW_FRAMES >= 64))
        else $error("zero frame estimate");

endmodule

bind frame_rate_window_meter_top fwm_checker #(
    .WINDOW_FRAMES (WINDOW_FRAMES)
) u_fwm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_operation (i_in.operation),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_fps      (o_out.fps_estimate)
);

@@ test/tb_frame_rate_window_meter_top.sv @@
`timescale 1ns / 1ps

module tb_frame_rate_window_meter_top;
    import fwm_pkg::*;

    localparam int WIN = WINDOW_FRAMES_DEF;

    // Predicts the frame rate estimate of every frame item and checks each result item.
    class fps_window_tracker;
        logic [DUR_W-1:0] durations [WIN];
        int unsigned      next_slot;
        logic [TS_W-1:0]  last_stamp;
        logic [DUR_W-1:0] one_second;
        logic [FPS_W-1:0] fps_due [$];
        int               errors;

        function new();
            foreach (durations[k]) durations[k] = '0;
            next_slot  = 0;
            last_stamp = '0;
            one_second = ONE_SECOND_RESET;
            errors     = 0;
        endfunction

        function void set_threshold(logic [DUR_W-1:0] value);
            one_second = value;
        endfunction

        function int pending();
            return fps_due.size();
        endfunction

        // Update the ring for one accepted item and queue the estimate it yields.
        function void take_item(logic op, logic [TS_W-1:0] stamp);
            logic [63:0]      sum;
            int unsigned      pos;
            logic [FPS_W-1:0] fps;
            if (op == OP_SET_REF) begin
                last_stamp = stamp;
                return;
            end
            // Only the low bits of the elapsed time are kept, so timer wrap is harmless.
            durations[next_slot] = DUR_W'(stamp - last_stamp);
            last_stamp = stamp;
            pos = next_slot;
            next_slot = (next_slot + 1) % WIN;
            // Walk from the newest entry back until the sum passes one second.
            sum = '0;
            fps = FPS_W'(WIN - 1);
            for (int n = 0; n < WIN; n++) begin
                sum += 64'(durations[pos]);
                if (sum > 64'(one_second)) begin
                    fps = FPS_W'(n + 1);
                    break;
                end
                pos = (pos == 0) ? WIN - 1 : pos - 1;
            end
            fps_due.push_back(fps);
        endfunction

        // Compare one result item with the oldest estimate still due.
        function void check_fps(logic [FPS_W-1:0] fps);
            logic [FPS_W-1:0] want;
            if (fps_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual fps %0d", $time, fps);
                errors++;
                return;
            end
            want = fps_due.pop_front();
            if (fps !== want) begin
                $display("%0t: fps mismatch, expected %0d, actual %0d", $time, want, fps);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [DUR_W-1:0] i_cfg_wdata;

    fwm_in_if  in_if ();
    fwm_out_if out_if ();

    fps_window_tracker tracker;
    logic [TS_W-1:0]   stamp_now;
    logic [DUR_W-1:0]  cur_threshold;
    bit                calm;
    bit                want_hold;

    frame_rate_window_meter_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Overall time limit for the run.
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random stalls, a calm stretch and one long hold-off.
    initial begin
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (want_hold && !hold_used) begin
                hold_used = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (calm) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= 30);
            end
        end
    end

    // Every accepted result item is checked at the edge that moves it.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            tracker.check_fps(out_if.fps_estimate);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Frame duration around one second divided by the target rate, with some noise.
    function automatic logic [63:0] frame_gap(input logic [DUR_W-1:0] limit, input int rate);
        logic [63:0] base;
        logic [63:0] spread;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) return 64'd0;
        if (pick < 8) return 64'($urandom());
        // Elapsed time beyond 32 bits, of which only the low part is kept.
        if (pick < 10) return rand64();
        base = (limit == 0) ? 64'($urandom_range(1, 3)) : 64'(limit) / rate;
        spread = base / 8;
        return base - spread / 2 + (rand64() % (spread + 1));
    endfunction

    // Offer one input item, with an optional gap before it, and wait until it is taken.
    task automatic offer_item(input logic op, input logic [TS_W-1:0] stamp);
        if (!calm && $urandom_range(0, 99) < 30) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.operation <= op;
        in_if.timestamp <= stamp;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        tracker.take_item(op, stamp);
        stamp_now = stamp;
    endtask

    task automatic offer_frame_after(input logic [63:0] gap);
        offer_item(OP_FRAME, stamp_now + gap);
    endtask

    // Change the threshold once the block has drained and gone idle.
    task automatic write_one_second(input logic [DUR_W-1:0] value);
        in_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (WIN + 8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_threshold(value);
        cur_threshold = value;
    endtask

    // Mostly well-formed frame sequences at a drifting rate, plus some noise.
    task automatic run_random_frames(input int count, input int calm_from, input int calm_to,
                                     input int hold_at);
        int          rate;
        int unsigned pick;
        rate = 30;
        for (int i = 0; i < count; i++) begin
            if (i % 24 == 0) rate = $urandom_range(1, 70);
            calm = (i >= calm_from && i < calm_to);
            if (i == hold_at) want_hold = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                offer_item(OP_SET_REF, rand64());
            end else if (pick < 10) begin
                offer_item(OP_FRAME, rand64());
            end else begin
                offer_frame_after(frame_gap(cur_threshold, rate));
            end
        end
        calm = 1'b0;
    endtask

    // Main sequence: reset, directed items, then random phases over several thresholds.
    initial begin
        tracker         = new();
        stamp_now       = '0;
        cur_threshold   = ONE_SECOND_RESET;
        calm            = 1'b0;
        want_hold       = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        in_if.valid     = 1'b0;
        in_if.operation = OP_FRAME;
        in_if.timestamp = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty history, a sum exactly at the threshold, and a single long frame.
        offer_item(OP_FRAME, 64'd0);
        offer_frame_after(64'(ONE_SECOND_RESET));
        offer_frame_after(64'd1);
        offer_frame_after(64'(ONE_SECOND_RESET) + 64'd1);
        // Timer wrap across the top of the 64-bit range.
        offer_item(OP_SET_REF, 64'hFFFF_FFFF_FFFF_FFF0);
        offer_item(OP_FRAME, 64'h0000_0000_0000_0010);
        offer_item(OP_SET_REF, 64'h0);
        offer_item(OP_FRAME, 64'hFFFF_FFFF_FFFF_FFFF);
        offer_item(OP_SET_REF, 64'h5555_5555_5555_5555);
        offer_item(OP_FRAME, 64'hAAAA_AAAA_AAAA_AAAA);
        offer_frame_after(64'h0123_4567_0000_0040);

        // Largest threshold: two full-scale durations are needed to pass it.
        write_one_second(32'hFFFF_FFFF);
        offer_frame_after(64'hFFFF_FFFF);
        offer_frame_after(64'hFFFF_FFFF);
        offer_frame_after(64'd1);

        // Zero threshold: any nonzero duration passes it.
        write_one_second(32'd0);
        offer_frame_after(64'd0);
        offer_frame_after(64'd1);
        offer_item(OP_SET_REF, stamp_now + 64'd5);
        offer_frame_after(64'd0);

        // Random phases; the first one has a calm stretch and the long hold-off.
        write_one_second(ONE_SECOND_RESET);
        run_random_frames(200, 100, 180, 40);
        write_one_second($urandom());
        run_random_frames(150, 0, 0, -1);
        write_one_second(32'd1000);
        run_random_frames(150, 0, 0, -1);
        write_one_second(32'd0);
        run_random_frames(100, 0, 0, -1);
        write_one_second(32'hFFFF_FFFF);
        run_random_frames(150, 0, 0, -1);
        write_one_second(ONE_SECOND_RESET);
        run_random_frames(200, 0, 0, -1);

        // Drain and let the last walk finish.
        in_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (WIN + 8) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
